/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPL_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`define ASSERT_IMPL_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/lqm_pkg.sv */
// Shared types and constants of the linked queue manager.
`default_nettype none

package lqm_pkg;

    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int STEP_W    = $clog2(POOL_SIZE);

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_LAST = STEP_W'(POOL_SIZE - 1);

    typedef enum logic [1:0] {
        OP_INSERT       = 2'd0,
        OP_REMOVE_HEAD  = 2'd1,
        OP_REMOVE_GIVEN = 2'd2,
        OP_PEEK         = 2'd3
    } t_lqm_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS2,
        ST_HEAD,
        ST_WALK
    } t_lqm_state;

    typedef struct packed {
        logic re;
        t_idx raddr;
        logic we;
        t_idx waddr;
        t_idx wdata;
    } t_lqm_ram_cmd;

    typedef struct packed {
        logic nonempty;
        t_idx tail;
        logic found;
        t_idx entry;
    } t_lqm_result;

endpackage

`default_nettype wire

/* hw/rtl/lqm_link_ram.sv */
// Single-port-write, single-port-read link memory with registered read data.
`default_nettype none

module lqm_link_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lqm_ctrl.sv */
// Operation sequencer: reads, walks and rewrites the next/prev link memories.
`default_nettype none

module lqm_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_opcode,
    input  wire logic                 i_queue_nonempty,
    input  wire lqm_pkg::t_idx        i_queue_tail,
    input  wire lqm_pkg::t_idx        i_entry_index,
    input  wire logic                 i_out_free,
    output logic                      o_emit,
    output lqm_pkg::t_lqm_result      o_result,
    output lqm_pkg::t_lqm_ram_cmd     o_next_cmd,
    output lqm_pkg::t_lqm_ram_cmd     o_prev_cmd,
    input  wire lqm_pkg::t_idx        i_next_rdata,
    input  wire lqm_pkg::t_idx        i_prev_rdata
);

    import lqm_pkg::*;

    t_lqm_state r_state, n_state;
    t_lqm_op    r_op;
    logic       r_ne;
    t_idx       r_t, r_p;
    t_idx       r_head, n_head;
    t_idx       r_cur, n_cur;
    t_step      r_steps, n_steps;

    logic accept;
    logic head_is_tail;
    logic cur_hit;
    logic walk_end;
    logic single;

    assign accept       = i_in_valid && (r_state == ST_IDLE);
    assign head_is_tail = (i_next_rdata == r_t);
    assign cur_hit      = (r_cur == r_p);
    assign walk_end     = cur_hit || (i_next_rdata == r_t) || (r_steps == STEP_LAST);
    // tail linked only to itself, seen on the first walk step
    assign single       = (r_steps == '0) && (i_next_rdata == r_t) && (i_prev_rdata == r_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= t_lqm_op'(i_opcode);
            r_ne <= i_queue_nonempty;
            r_t  <= i_queue_tail;
            r_p  <= i_entry_index;
        end
        r_head  <= n_head;
        r_cur   <= n_cur;
        r_steps <= n_steps;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (r_op == OP_INSERT && r_ne) begin
                    n_state = ST_INS2;
                end else if (r_op == OP_INSERT || !r_ne || r_op == OP_PEEK) begin
                    if (i_out_free) n_state = ST_IDLE;
                end else if (r_op == OP_REMOVE_HEAD) begin
                    if (!head_is_tail) begin
                        n_state = ST_HEAD;
                    end else if (i_out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_INS2, ST_HEAD: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            ST_WALK: begin
                if (walk_end && i_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory commands, result and walk registers
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        o_next_cmd = '0;
        o_prev_cmd = '0;
        o_emit     = 1'b0;
        o_result   = '0;
        n_head     = r_head;
        n_cur      = r_cur;
        n_steps    = r_steps;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_next_cmd.re    = 1'b1;
                    o_next_cmd.raddr = i_queue_tail;
                    o_prev_cmd.re    = 1'b1;
                    o_prev_cmd.raddr = i_queue_tail;
                end
            end
            ST_DECODE: begin
                priority if (r_op == OP_INSERT && !r_ne) begin
                    if (i_out_free) begin
                        o_next_cmd.we    = 1'b1;
                        o_next_cmd.waddr = r_p;
                        o_next_cmd.wdata = r_p;
                        o_prev_cmd.we    = 1'b1;
                        o_prev_cmd.waddr = r_p;
                        o_prev_cmd.wdata = r_p;
                        o_emit           = 1'b1;
                        o_result         = '{1'b1, r_p, 1'b1, r_p};
                    end
                end else if (r_op == OP_INSERT) begin
                    // next[p] = old head, prev[old head] = p
                    o_next_cmd.we    = 1'b1;
                    o_next_cmd.waddr = r_p;
                    o_next_cmd.wdata = i_next_rdata;
                    o_prev_cmd.we    = 1'b1;
                    o_prev_cmd.waddr = i_next_rdata;
                    o_prev_cmd.wdata = r_p;
                end else if (!r_ne) begin
                    o_emit = i_out_free;
                end else if (r_op == OP_PEEK) begin
                    o_emit   = i_out_free;
                    o_result = '{1'b1, r_t, 1'b1, i_next_rdata};
                end else if (r_op == OP_REMOVE_HEAD) begin
                    if (head_is_tail) begin
                        o_emit   = i_out_free;
                        o_result = '{1'b0, '0, 1'b1, i_next_rdata};
                    end else begin
                        o_next_cmd.re    = 1'b1;
                        o_next_cmd.raddr = i_next_rdata;
                        o_prev_cmd.re    = 1'b1;
                        o_prev_cmd.raddr = i_next_rdata;
                        n_head           = i_next_rdata;
                    end
                end else begin
                    // walk starts at the tail with its links already read
                    n_cur   = r_t;
                    n_steps = '0;
                end
            end
            ST_INS2: begin
                if (i_out_free) begin
                    o_prev_cmd.we    = 1'b1;
                    o_prev_cmd.waddr = r_p;
                    o_prev_cmd.wdata = r_t;
                    o_next_cmd.we    = 1'b1;
                    o_next_cmd.waddr = r_t;
                    o_next_cmd.wdata = r_p;
                    o_emit           = 1'b1;
                    o_result         = '{1'b1, r_p, 1'b1, r_p};
                end
            end
            ST_HEAD: begin
                if (i_out_free) begin
                    o_next_cmd.we    = 1'b1;
                    o_next_cmd.waddr = i_prev_rdata;
                    o_next_cmd.wdata = i_next_rdata;
                    o_prev_cmd.we    = 1'b1;
                    o_prev_cmd.waddr = i_next_rdata;
                    o_prev_cmd.wdata = r_t;
                    o_emit           = 1'b1;
                    o_result         = '{1'b1, r_t, 1'b1, r_head};
                end
            end
            ST_WALK: begin
                priority if (!walk_end) begin
                    o_next_cmd.re    = 1'b1;
                    o_next_cmd.raddr = i_next_rdata;
                    o_prev_cmd.re    = 1'b1;
                    o_prev_cmd.raddr = i_next_rdata;
                    n_cur            = i_next_rdata;
                    n_steps          = r_steps + 1'b1;
                end else if (!i_out_free) begin
                    o_emit = 1'b0;
                end else if (cur_hit && single) begin
                    o_emit   = 1'b1;
                    o_result = '{1'b0, '0, 1'b1, r_p};
                end else if (cur_hit) begin
                    o_next_cmd.we    = 1'b1;
                    o_next_cmd.waddr = i_prev_rdata;
                    o_next_cmd.wdata = i_next_rdata;
                    o_prev_cmd.we    = 1'b1;
                    o_prev_cmd.waddr = i_next_rdata;
                    o_prev_cmd.wdata = i_prev_rdata;
                    o_emit           = 1'b1;
                    o_result         = '{1'b1, (r_p == r_t) ? i_prev_rdata : r_t, 1'b1, r_p};
                end else begin
                    o_emit   = 1'b1;
                    o_result = '{1'b1, r_t, 1'b0, '0};
                end
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/linked_queue_manager.sv */
// Top level of the linked queue manager: link memories, sequencer, result register.
`default_nettype none

// Many FIFO queues share one pool of 64 entries, each queue a circular doubly
// linked list named by its tail; the caller passes the queue's nonempty bit and
// tail with every beat and gets the updated pair back together with the entry
// inserted, removed or peeked. The next and prev links sit in two synchronous
// memories with registered read data. An item passes through ST_DECODE alone
// (peek, empty queue, insert into an empty queue, remove head of a one-entry
// queue), through ST_DECODE then ST_INS2 or ST_HEAD (insert into a nonempty
// queue, remove head of a longer queue) or through ST_DECODE then ST_WALK for
// remove-given, which walks from the tail one entry per pass through the
// next-link memory's read port, at most 64 entries. A finished result waits
// in its last state while the output register holds a stalled result. Link
// memories are undefined after reset and hold nothing until entries are
// inserted. A new beat is taken while the previous result waits at the output.
module linked_queue_manager (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [1:0]    i_opcode,
    input  wire logic          i_queue_nonempty,
    input  wire lqm_pkg::t_idx i_queue_tail,
    input  wire lqm_pkg::t_idx i_entry_index,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic               o_new_nonempty,
    output lqm_pkg::t_idx      o_new_tail,
    output logic               o_found,
    output lqm_pkg::t_idx      o_result_entry
);

    import lqm_pkg::*;

    t_lqm_ram_cmd next_cmd, prev_cmd;
    t_idx         next_rdata, prev_rdata;
    t_lqm_result  result;
    t_lqm_result  r_out;
    logic         r_out_valid;
    logic         emit;
    logic         out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    lqm_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_queue_nonempty (i_queue_nonempty),
        .i_queue_tail     (i_queue_tail),
        .i_entry_index    (i_entry_index),
        .i_out_free       (out_free),
        .o_emit           (emit),
        .o_result         (result),
        .o_next_cmd       (next_cmd),
        .o_prev_cmd       (prev_cmd),
        .i_next_rdata     (next_rdata),
        .i_prev_rdata     (prev_rdata)
    );

    lqm_link_ram #(.DEPTH(POOL_SIZE), .WIDTH(IDX_W)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_cmd.we),
        .i_waddr (next_cmd.waddr),
        .i_wdata (next_cmd.wdata),
        .i_re    (next_cmd.re),
        .i_raddr (next_cmd.raddr),
        .o_rdata (next_rdata)
    );

    lqm_link_ram #(.DEPTH(POOL_SIZE), .WIDTH(IDX_W)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_cmd.we),
        .i_waddr (prev_cmd.waddr),
        .i_wdata (prev_cmd.wdata),
        .i_re    (prev_cmd.re),
        .i_raddr (prev_cmd.raddr),
        .o_rdata (prev_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_new_nonempty = r_out.nonempty;
    assign o_new_tail     = r_out.tail;
    assign o_found        = r_out.found;
    assign o_result_entry = r_out.entry;

    // writes and reads of a link memory never meet in one cycle, so no bypass
`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_next_no_rw, i_clk, i_rst_n, !(next_cmd.re && next_cmd.we))
    `ASSERT_ALWAYS(a_prev_no_rw, i_clk, i_rst_n, !(prev_cmd.re && prev_cmd.we))
    `ASSERT_IMPL_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_ALWAYS(a_emit_slot_free, i_clk, i_rst_n, !emit || !r_out_valid || !i_out_stall)

endmodule

`default_nettype wire

/* bench/linked_queue_manager_tb.sv */
// Self-checking bench for the linked queue manager: shadow link pool, random queue traffic.
module linked_queue_manager_tb;
    import lqm_pkg::*;

    localparam int NUM_Q        = 4;
    localparam int FREE         = -1;
    localparam int DRAIN_CYCLES = 80;

    logic     i_clk            = 1'b0;
    logic     i_rst_n          = 1'b0;
    logic     i_in_valid       = 1'b0;
    logic     o_in_stall;
    t_lqm_op  i_opcode         = OP_INSERT;
    logic     i_queue_nonempty = 1'b0;
    t_idx     i_queue_tail     = '0;
    t_idx     i_entry_index    = '0;
    logic     o_out_valid;
    logic     i_out_stall      = 1'b0;
    logic     o_new_nonempty;
    t_idx     o_new_tail;
    logic     o_found;
    t_idx     o_result_entry;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    linked_queue_manager dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_queue_nonempty (i_queue_nonempty),
        .i_queue_tail     (i_queue_tail),
        .i_entry_index    (i_entry_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_new_nonempty   (o_new_nonempty),
        .o_new_tail       (o_new_tail),
        .o_found          (o_found),
        .o_result_entry   (o_result_entry)
    );

    // shadow copy of the link memories
    t_idx link_next [POOL_SIZE];
    t_idx link_prev [POOL_SIZE];

    t_lqm_result expected_results [$];
    int errors   = 0;
    int idle_pct = 25;

    // queues tracked by the stimulus side
    logic ne_q    [NUM_Q];
    t_idx tail_q  [NUM_Q];
    int   owner   [POOL_SIZE];
    int   build_order [POOL_SIZE];

    function automatic t_lqm_result predict_queue_op(input t_lqm_op op, input logic ne,
                                                     input t_idx t, input t_idx p);
        t_lqm_result r;
        t_idx h, hp, hn, cur, cp, cn;
        logic done;
        r = '0;
        if (op == OP_INSERT) begin
            if (!ne) begin
                link_next[p] = p;
                link_prev[p] = p;
            end else begin
                h = link_next[t];
                link_next[p] = h;
                link_prev[h] = p;
                link_prev[p] = t;
                link_next[t] = p;
            end
            r = '{1'b1, p, 1'b1, p};
        end else if (!ne) begin
            r = '0;
        end else if (op == OP_PEEK) begin
            r = '{1'b1, t, 1'b1, link_next[t]};
        end else if (op == OP_REMOVE_HEAD) begin
            h = link_next[t];
            if (h == t) begin
                r = '{1'b0, t_idx'(0), 1'b1, h};
            end else begin
                hp = link_prev[h];
                hn = link_next[h];
                link_next[hp] = hn;
                link_prev[hn] = t;
                r = '{1'b1, t, 1'b1, h};
            end
        end else if (link_next[t] == t && link_prev[t] == t) begin
            if (p == t)
                r = '{1'b0, t_idx'(0), 1'b1, p};
            else
                r = '{1'b1, t, 1'b0, t_idx'(0)};
        end else begin
            // membership walk, gives up after a full pool of steps
            r = '{1'b1, t, 1'b0, t_idx'(0)};
            cur = t;
            done = 1'b0;
            for (int steps = 0; steps < POOL_SIZE && !done; steps++) begin
                if (cur == p) begin
                    cp = link_prev[cur];
                    cn = link_next[cur];
                    link_next[cp] = cn;
                    link_prev[cn] = cp;
                    r = '{1'b1, (p == t) ? cp : t, 1'b1, p};
                    done = 1'b1;
                end else begin
                    cur = link_next[cur];
                    if (cur == t)
                        done = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic send_beat(input t_lqm_op op, input logic ne, input t_idx tail,
                             input t_idx entry, output t_lqm_result res);
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_queue_nonempty <= ne;
        i_queue_tail     <= tail;
        i_entry_index    <= entry;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        res = predict_queue_op(op, ne, tail, entry);
        expected_results.push_back(res);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic queue_op(input int q, input t_lqm_op op, input t_idx entry);
        t_lqm_result res;
        t_idx tail;
        tail = ne_q[q] ? tail_q[q] : t_idx'($urandom);  // tail is don't-care when empty
        send_beat(op, ne_q[q], tail, entry, res);
        ne_q[q]   = res.nonempty;
        tail_q[q] = res.tail;
        if (res.found)
            owner[res.entry] = (op == OP_INSERT) ? q : FREE;
    endtask

    task automatic send_noise(input int count);
        t_lqm_result res;
        repeat (count)
            send_beat(t_lqm_op'($urandom_range(3)), 1'($urandom), t_idx'($urandom),
                      t_idx'($urandom), res);
    endtask

    function automatic int pick_owned(input int who);
        int cand [$];
        foreach (owner[i])
            if (owner[i] == who)
                cand.push_back(i);
        if (cand.size() == 0)
            return FREE;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    function automatic void forget_queues();
        foreach (ne_q[q]) begin
            ne_q[q]   = 1'b0;
            tail_q[q] = '0;
        end
        foreach (owner[i])
            owner[i] = FREE;
    endfunction

    function automatic void report_mismatch(input string field, input logic [5:0] exp_v,
                                            input logic [5:0] act_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    endfunction

    // result checker and receiver stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_lqm_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got tail %0d entry %0d",
                         $time, o_new_tail, o_result_entry);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_new_nonempty !== exp_r.nonempty)
                    report_mismatch("new_nonempty", exp_r.nonempty, o_new_nonempty);
                if (o_new_tail !== exp_r.tail)
                    report_mismatch("new_tail", exp_r.tail, o_new_tail);
                if (o_found !== exp_r.found)
                    report_mismatch("found", exp_r.found, o_found);
                if (o_result_entry !== exp_r.entry)
                    report_mismatch("result_entry", exp_r.entry, o_result_entry);
            end
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 11);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // every link gets written here, so later beats never read an unwritten one
    task automatic prime_pool();
        int j, tmp;
        for (int i = 0; i < POOL_SIZE; i++)
            build_order[i] = i;
        for (int i = POOL_SIZE - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = build_order[i];
            build_order[i] = build_order[j];
            build_order[j] = tmp;
        end
        forget_queues();
        for (int i = 0; i < POOL_SIZE; i++)
            queue_op(0, OP_INSERT, t_idx'(build_order[i]));
    endtask

    task automatic test_long_walk();
        queue_op(0, OP_REMOVE_GIVEN, t_idx'(build_order[POOL_SIZE - 2]));  // deepest entry
        queue_op(0, OP_REMOVE_GIVEN, t_idx'(build_order[POOL_SIZE - 2]));  // gone: not found
        queue_op(0, OP_REMOVE_GIVEN, tail_q[0]);                           // tail steps back
    endtask

    task automatic test_head_peek();
        queue_op(0, OP_PEEK, t_idx'($urandom));
        queue_op(0, OP_REMOVE_HEAD, t_idx'($urandom));
        queue_op(0, OP_PEEK, '0);
    endtask

    task automatic test_empty_queue();
        t_lqm_result res;
        send_beat(OP_REMOVE_HEAD, 1'b0, '1, '0, res);
        send_beat(OP_REMOVE_GIVEN, 1'b0, '0, '1, res);
        send_beat(OP_PEEK, 1'b0, t_idx'($urandom), t_idx'($urandom), res);
    endtask

    task automatic test_single_entry();
        int e;
        e = pick_owned(FREE);
        queue_op(1, OP_INSERT, t_idx'(e));
        queue_op(1, OP_REMOVE_GIVEN, t_idx'(e ^ 1));  // other entry: not found
        queue_op(1, OP_PEEK, '0);
        queue_op(1, OP_REMOVE_GIVEN, t_idx'(e));
        queue_op(1, OP_INSERT, t_idx'(e));
        queue_op(1, OP_REMOVE_HEAD, '0);
    endtask

    task automatic test_index_extremes();
        queue_op(0, OP_REMOVE_GIVEN, '0);
        queue_op(0, OP_REMOVE_GIVEN, '1);
        queue_op(1, OP_INSERT, '1);
        queue_op(1, OP_INSERT, '0);
        queue_op(1, OP_REMOVE_HEAD, '0);
        queue_op(1, OP_REMOVE_GIVEN, '0);
    endtask

    task automatic test_requeue();
        queue_op(0, OP_INSERT, t_idx'(pick_owned(0)));  // entry already on the queue
    endtask

    // next chain from the tail falls into a loop that skips the tail
    task automatic test_broken_links();
        t_lqm_result res;
        t_idx u, v;
        u = t_idx'($urandom);
        v = u ^ 6'd1;
        send_beat(OP_INSERT, 1'b0, '0, u, res);
        send_beat(OP_INSERT, 1'b0, '0, v, res);
        send_beat(OP_INSERT, 1'b1, u, v, res);
        send_beat(OP_INSERT, 1'b0, '0, u, res);
        send_beat(OP_REMOVE_GIVEN, 1'b1, v, u ^ 6'd2, res);
        forget_queues();
    endtask

    task automatic test_random_traffic(input int total);
        int sent, round_len, q, pick, e, grow;
        sent = 0;
        while (sent < total) begin
            round_len = $urandom_range(60, 140);
            case ($urandom_range(2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            if (total - sent < 150)
                idle_pct = 0;
            grow = $urandom_range(35, 65);
            repeat (round_len) begin
                q = $urandom_range(NUM_Q - 1);
                pick = $urandom_range(99);
                if (pick < grow) begin
                    e = pick_owned(FREE);
                    if (e == FREE)
                        queue_op(q, OP_REMOVE_HEAD, t_idx'($urandom));
                    else
                        queue_op(q, OP_INSERT, t_idx'(e));
                end else if (pick < grow + (100 - grow) / 3) begin
                    queue_op(q, OP_REMOVE_HEAD, t_idx'($urandom));
                end else if (pick < 88) begin
                    e = pick_owned(q);
                    if (e == FREE)
                        e = $urandom_range(POOL_SIZE - 1);
                    queue_op(q, OP_REMOVE_GIVEN, t_idx'(e));
                end else if (pick < 94) begin
                    queue_op(q, OP_REMOVE_GIVEN, t_idx'($urandom));
                end else begin
                    queue_op(q, OP_PEEK, t_idx'($urandom));
                end
            end
            sent += round_len;
            if (total - sent >= 150) begin
                // raw beats may break the lists, so tracking restarts afterward
                pick = $urandom_range(4, 14);
                send_noise(pick);
                sent += pick;
                forget_queues();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        prime_pool();
        test_long_walk();
        test_head_peek();
        test_empty_queue();
        test_single_entry();
        test_index_extremes();
        test_requeue();
        test_broken_links();
        test_random_traffic(1300);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
